// File: src/mtm_pkg.sv
// Shared types, constants and helper functions of the MUS score event parser.
package mtm_pkg;

    localparam int CHANNEL_COUNT = 16;
    localparam int CHAN_BITS     = $clog2(CHANNEL_COUNT);
    localparam int TIME_BITS     = 32;

    localparam logic [7:0] END_MARK  = 8'h60;
    localparam logic [2:0] GRP_LIMIT = 3'd5;

    localparam logic [2:0] GRP_RELEASE = 3'd0;
    localparam logic [2:0] GRP_PLAY    = 3'd1;
    localparam logic [2:0] GRP_PITCH   = 3'd2;
    localparam logic [2:0] GRP_SYSTEM  = 3'd3;

    localparam logic [7:0] SYS_LOW     = 8'd10;
    localparam logic [7:0] SYS_HIGH    = 8'd14;
    localparam logic [7:0] CTRL_LIMIT  = 8'd10;

    localparam logic [1:0] COUNT_ONE = 2'd1;
    localparam logic [1:0] COUNT_TWO = 2'd2;

    typedef enum logic [4:0] {
        PH_HEADER  = 5'b00001,
        PH_FIRST   = 5'b00010,
        PH_SECOND  = 5'b00100,
        PH_DELTA   = 5'b01000,
        PH_PROGRAM = 5'b10000
    } phase_t;

    typedef enum logic [2:0] {
        KIND_NOTE    = 3'd0,
        KIND_PITCH   = 3'd1,
        KIND_CTRL    = 3'd2,
        KIND_PROGRAM = 3'd3,
        KIND_EOT     = 3'd4,
        KIND_ERROR   = 3'd5
    } kind_t;

    typedef struct packed {
        logic [7:0] score_byte;
        logic       final_byte;
    } byte_beat_t;

    typedef struct packed {
        kind_t       event_kind;
        logic [3:0]  midi_channel;
        logic [7:0]  first_data;
        logic [7:0]  second_data;
        logic [1:0]  data_count;
        logic [31:0] event_time;
        logic        run_last;
    } event_beat_t;

    typedef struct packed {
        phase_t               phase;
        logic [7:0]           header;
        logic [7:0]           first_held;
        logic [TIME_BITS-1:0] running;
        logic [TIME_BITS-1:0] delta;
    } parse_state_t;

    typedef struct packed {
        logic       emit;
        logic       two;
        logic       stop;
        logic       vel_we;
        logic [7:0] vel_data;
    } step_ctl_t;

    function automatic logic [CHAN_BITS-1:0] held_channel(input logic [7:0] header);
        logic [3:0] c;
        c = header[3:0];
        if (c == 4'hF) begin
            c = 4'd9;
        end else if (c >= 4'd9) begin
            c = c + 4'd1;
        end
        return CHAN_BITS'(c);
    endfunction

    function automatic logic [7:0] ctrl_map(input logic [3:0] n);
        logic [7:0] v;
        unique case (n)
            4'd0:    v = 8'd0;
            4'd1:    v = 8'd0;
            4'd2:    v = 8'd1;
            4'd3:    v = 8'd7;
            4'd4:    v = 8'd10;
            4'd5:    v = 8'd11;
            4'd6:    v = 8'd91;
            4'd7:    v = 8'd93;
            4'd8:    v = 8'd64;
            4'd9:    v = 8'd67;
            4'd10:   v = 8'd120;
            4'd11:   v = 8'd123;
            4'd12:   v = 8'd126;
            4'd13:   v = 8'd127;
            4'd14:   v = 8'd121;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

// File: src/mtm_byte_if.sv
// Valid/ready channel that carries score bytes into the parser.
interface mtm_byte_if
    import mtm_pkg::*;
();
    logic       valid;
    logic       ready;
    byte_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/mtm_event_if.sv
// Valid/ready channel that carries decoded MIDI events out of the parser.
interface mtm_event_if
    import mtm_pkg::*;
();
    logic        valid;
    logic        ready;
    event_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/mus_to_midi_event_parser.sv
// Top level of the MUS score event parser: state, velocity store and result register.
//
//   channel    | dir | beat payload
//   score_in   | in  | score_byte, final_byte
//   event_out  | out | event_kind, midi_channel, first_data, second_data,
//              |     | data_count, event_time, run_last
//
// Bytes decode one per cycle unless a held result stalls; each result goes out registered.
// A byte that closes an event on the last score byte gives two beats; the end-of-track beat
// is presented in the cycle after the event beat drains.
// rst_n clears the parse state, the running time and all sixteen velocities at once.
// score_in.ready follows event_out.ready while a result is held; once the track has ended,
// further bytes are taken and dropped.
module mus_to_midi_event_parser
    import mtm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mtm_byte_if.sink    score_in,
    mtm_event_if.source event_out
);

    parse_state_t st_reg;
    parse_state_t st_next;
    step_ctl_t    ctl;
    event_beat_t  res;
    event_beat_t  out_reg;
    event_beat_t  out_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic         eot_pending_reg;
    logic         eot_pending_next;
    logic         stopped_reg;
    logic [7:0]   vel_reg [CHANNEL_COUNT];
    logic [7:0]   vel_rd;
    logic [CHAN_BITS-1:0] vel_idx;
    logic         accept;
    logic         step;
    logic         drain;

    assign vel_idx = held_channel(st_reg.header);
    assign vel_rd  = vel_reg[vel_idx];

    mtm_decode u_decode (
        .st         (st_reg),
        .score_byte (score_in.data.score_byte),
        .final_byte (score_in.data.final_byte),
        .vel_rd     (vel_rd),
        .st_next    (st_next),
        .ctl        (ctl),
        .res        (res)
    );

    assign score_in.ready  = stopped_reg || !out_valid_reg || event_out.ready;
    assign accept          = score_in.valid && score_in.ready;
    assign step            = accept && !stopped_reg;
    assign drain           = out_valid_reg && event_out.ready;
    assign event_out.valid = out_valid_reg;
    assign event_out.data  = out_reg;

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        eot_pending_next = eot_pending_reg;
        out_next         = out_reg;
        if (step && ctl.emit) begin
            out_valid_next   = 1'b1;
            eot_pending_next = ctl.two;
            out_next         = res;
        end else if (drain) begin
            out_valid_next   = eot_pending_reg;
            eot_pending_next = 1'b0;
            if (eot_pending_reg) begin
                out_next            = '0;
                out_next.event_kind = KIND_EOT;
                out_next.event_time = out_reg.event_time;
                out_next.run_last   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg.phase      <= PH_HEADER;
            st_reg.header     <= '0;
            st_reg.first_held <= '0;
            st_reg.running    <= '0;
            st_reg.delta      <= '0;
            stopped_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
            eot_pending_reg   <= 1'b0;
            out_reg           <= '0;
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                vel_reg[i] <= '0;
            end
        end else begin
            out_valid_reg   <= out_valid_next;
            eot_pending_reg <= eot_pending_next;
            out_reg         <= out_next;
            if (step) begin
                st_reg <= st_next;
                if (ctl.stop) begin
                    stopped_reg <= 1'b1;
                end
                if (ctl.vel_we) begin
                    vel_reg[vel_idx] <= ctl.vel_data;
                end
            end
        end
    end

`ifndef SYNTH
    // The trailing end-of-track beat only exists once the track has stopped.
    a_pending_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        eot_pending_reg |-> (stopped_reg && out_valid_reg))
        else $error("end-of-track pending without a held stopping result");

    // After the last beat of a stopped track drains, nothing new is produced.
    a_quiet_after_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (stopped_reg && !eot_pending_reg && event_out.valid && event_out.ready)
        |=> !event_out.valid)
        else $error("result produced after the track stopped");

    // A held first beat with a pending end-of-track is never marked as the last.
    a_pending_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        eot_pending_reg |-> !out_reg.run_last)
        else $error("first of two beats marked as last");

    // The time stamp of the trailing end-of-track matches the event before it.
    a_eot_time: assert property (@(posedge clk) disable iff (!rst_n)
        (eot_pending_reg && event_out.ready) |=>
        (event_out.valid && event_out.data.event_kind == KIND_EOT
         && event_out.data.event_time == $past(event_out.data.event_time)))
        else $error("trailing end-of-track beat is wrong");
`endif

endmodule

// File: src/mtm_decode.sv
// Combinational step logic: decodes one score byte against the parser state.
module mtm_decode
    import mtm_pkg::*;
(
    input  parse_state_t st,
    input  logic [7:0]   score_byte,
    input  logic         final_byte,
    input  logic [7:0]   vel_rd,
    output parse_state_t st_next,
    output step_ctl_t    ctl,
    output event_beat_t  res
);

    logic [2:0]           grp_hdr;
    logic [2:0]           grp_held;
    logic                 do_event;
    logic                 do_finish;
    kind_t                ev_kind;
    kind_t                fin_kind;
    logic [7:0]           ev_d1;
    logic [7:0]           ev_d2;
    logic [1:0]           ev_cnt;
    logic [TIME_BITS-1:0] delta_sum;

    assign grp_hdr   = score_byte[6:4];
    assign grp_held  = st.header[6:4];
    assign delta_sum = {st.delta[TIME_BITS-8:0], 7'b0} + TIME_BITS'(score_byte[6:0]);

    always_comb
    begin
        st_next   = st;
        do_event  = 1'b0;
        do_finish = 1'b0;
        ev_kind   = KIND_NOTE;
        fin_kind  = KIND_EOT;
        ev_d1     = '0;
        ev_d2     = '0;
        ev_cnt    = COUNT_TWO;
        ctl       = '0;

        unique case (st.phase)
            PH_FIRST:
            begin
                priority if (grp_held == GRP_RELEASE) begin
                    do_event = 1'b1;
                    ev_d1    = score_byte;
                end else if (grp_held == GRP_PLAY) begin
                    if (score_byte[7]) begin
                        st_next.first_held = {1'b0, score_byte[6:0]};
                        st_next.phase      = PH_SECOND;
                    end else begin
                        do_event = 1'b1;
                        ev_d1    = score_byte;
                        ev_d2    = vel_rd;
                    end
                end else if (grp_held == GRP_PITCH) begin
                    do_event = 1'b1;
                    ev_kind  = KIND_PITCH;
                    ev_d1    = {score_byte[0], 7'b0};
                    ev_d2    = {1'b0, score_byte[7:1]};
                end else if (grp_held == GRP_SYSTEM) begin
                    if (score_byte >= SYS_LOW && score_byte <= SYS_HIGH) begin
                        do_event = 1'b1;
                        ev_kind  = KIND_CTRL;
                        ev_d1    = ctrl_map(score_byte[3:0]);
                        ev_d2    = 8'd1;
                    end else begin
                        do_finish = 1'b1;
                        fin_kind  = KIND_ERROR;
                    end
                end else begin
                    if (score_byte == 8'd0) begin
                        st_next.phase = PH_PROGRAM;
                    end else if (score_byte < CTRL_LIMIT) begin
                        st_next.first_held = ctrl_map(score_byte[3:0]);
                        st_next.phase      = PH_SECOND;
                    end else begin
                        do_finish = 1'b1;
                        fin_kind  = KIND_ERROR;
                    end
                end
                if (!do_event && !do_finish && final_byte) begin
                    do_finish = 1'b1;
                    fin_kind  = KIND_ERROR;
                end
            end
            PH_SECOND:
            begin
                do_event = 1'b1;
                ev_d1    = st.first_held;
                ev_d2    = score_byte;
                if (grp_held == GRP_PLAY) begin
                    ctl.vel_we   = 1'b1;
                    ctl.vel_data = score_byte;
                end else begin
                    ev_kind = KIND_CTRL;
                end
            end
            PH_PROGRAM:
            begin
                do_event = 1'b1;
                ev_kind  = KIND_PROGRAM;
                ev_d1    = score_byte;
                ev_cnt   = COUNT_ONE;
            end
            PH_DELTA:
            begin
                st_next.delta = delta_sum;
                if (!score_byte[7]) begin
                    st_next.running = st.running + delta_sum;
                    st_next.phase   = PH_HEADER;
                end
                if (final_byte) begin
                    do_finish = 1'b1;
                end
            end
            PH_HEADER:
            begin
                if (score_byte == END_MARK) begin
                    do_finish = 1'b1;
                end else begin
                    st_next.header = score_byte;
                    if (grp_hdr >= GRP_LIMIT || final_byte) begin
                        do_finish = 1'b1;
                        fin_kind  = KIND_ERROR;
                    end else begin
                        st_next.phase = PH_FIRST;
                    end
                end
            end
            default:
            begin
                st_next.phase = PH_HEADER;
            end
        endcase

        res            = '0;
        res.event_time = 32'(st_next.running);
        res.run_last   = 1'b1;
        if (do_event) begin
            ctl.emit         = 1'b1;
            res.event_kind   = ev_kind;
            res.midi_channel = 4'(held_channel(st.header));
            res.first_data   = ev_d1;
            res.second_data  = ev_d2;
            res.data_count   = ev_cnt;
            if (final_byte) begin
                ctl.two      = 1'b1;
                ctl.stop     = 1'b1;
                res.run_last = 1'b0;
            end else if (st.header[7]) begin
                st_next.delta = '0;
                st_next.phase = PH_DELTA;
            end else begin
                st_next.phase = PH_HEADER;
            end
        end else if (do_finish) begin
            ctl.emit       = 1'b1;
            ctl.stop       = 1'b1;
            res.event_kind = fin_kind;
        end
    end

endmodule

// File: tb/mus_to_midi_event_parser_tb.sv
// Self-checking testbench of the MUS score event parser: byte stimulus, event prediction, checks.
module mus_to_midi_event_parser_tb;
    import mtm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] GRP_CONTROLLER = 3'd4;
    localparam logic [7:0] CTRL_PROGRAM   = 8'd0;
    localparam logic [7:0] CONTROLLER_NUMBER [0:14] =
        '{8'd0, 8'd0, 8'd1, 8'd7, 8'd10, 8'd11, 8'd91, 8'd93,
          8'd64, 8'd67, 8'd120, 8'd123, 8'd126, 8'd127, 8'd121};

    logic clk;
    logic rst_n;

    mtm_byte_if  score_if ();
    mtm_event_if event_if ();

    mus_to_midi_event_parser dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .score_in  (score_if),
        .event_out (event_if)
    );

    phase_t      song_phase;
    logic [7:0]  song_header;
    logic [7:0]  song_held;
    logic [7:0]  song_velocity [CHANNEL_COUNT];
    logic [31:0] song_clock;
    logic [31:0] song_delta;
    bit          song_stopped;

    event_beat_t midi_event_q [$];
    event_beat_t oldest_event;
    logic [7:0]  score_q [$];

    int    sent_bytes;
    int    events_seen;
    int    mismatches;
    int    hold_left;
    int    stall_left;
    bit    quiet;
    string ending_name;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [3:0] midi_channel_of(input logic [7:0] header);
        if (header[3:0] == 4'hF)
        begin
            return 4'd9;
        end
        if (header[3:0] >= 4'd9)
        begin
            return header[3:0] + 4'd1;
        end
        return header[3:0];
    endfunction

    function automatic logic [7:0] make_header(input bit timed, input logic [2:0] grp,
                                               input logic [3:0] chan);
        return {timed, grp, chan};
    endfunction

    task automatic expect_event(input kind_t kind, input logic [3:0] chan,
                                input logic [7:0] d1, input logic [7:0] d2,
                                input logic [1:0] cnt);
        event_beat_t ev;
        ev.event_kind   = kind;
        ev.midi_channel = chan;
        ev.first_data   = d1;
        ev.second_data  = d2;
        ev.data_count   = cnt;
        ev.event_time   = song_clock;
        ev.run_last     = 1'b0;
        midi_event_q.push_back(ev);
    endtask

    task automatic close_track(input kind_t kind);
        expect_event(kind, 4'd0, 8'd0, 8'd0, 2'd0);
        song_stopped = 1'b1;
    endtask

    task automatic complete_event(input kind_t kind, input logic [7:0] d1,
                                  input logic [7:0] d2, input logic [1:0] cnt, input bit fin);
        expect_event(kind, midi_channel_of(song_header), d1, d2, cnt);
        if (fin)
        begin
            close_track(KIND_EOT);
        end
        else if (song_header[7])
        begin
            song_delta = '0;
            song_phase = PH_DELTA;
        end
        else
        begin
            song_phase = PH_HEADER;
        end
    endtask

    task automatic decode_score_byte(input logic [7:0] b, input bit fin);
        int before_count;
        before_count = midi_event_q.size();
        if (!song_stopped)
        begin
            case (song_phase)
                PH_FIRST:
                begin
                    case (song_header[6:4])
                        GRP_RELEASE:
                            complete_event(KIND_NOTE, b, 8'd0, COUNT_TWO, fin);
                        GRP_PLAY:
                            if (b[7])
                            begin
                                song_held  = {1'b0, b[6:0]};
                                song_phase = PH_SECOND;
                            end
                            else
                            begin
                                complete_event(KIND_NOTE, b,
                                               song_velocity[midi_channel_of(song_header)],
                                               COUNT_TWO, fin);
                            end
                        GRP_PITCH:
                            complete_event(KIND_PITCH, {b[0], 7'd0}, {1'b0, b[7:1]},
                                           COUNT_TWO, fin);
                        GRP_SYSTEM:
                            if (b >= SYS_LOW && b <= SYS_HIGH)
                            begin
                                complete_event(KIND_CTRL, CONTROLLER_NUMBER[b[3:0]], 8'd1,
                                               COUNT_TWO, fin);
                            end
                            else
                            begin
                                close_track(KIND_ERROR);
                            end
                        default:
                            if (b == CTRL_PROGRAM)
                            begin
                                song_phase = PH_PROGRAM;
                            end
                            else if (b < CTRL_LIMIT)
                            begin
                                song_held  = CONTROLLER_NUMBER[b[3:0]];
                                song_phase = PH_SECOND;
                            end
                            else
                            begin
                                close_track(KIND_ERROR);
                            end
                    endcase
                    if (midi_event_q.size() == before_count && fin)
                    begin
                        close_track(KIND_ERROR);
                    end
                end
                PH_SECOND:
                begin
                    if (song_header[6:4] == GRP_PLAY)
                    begin
                        song_velocity[midi_channel_of(song_header)] = b;
                        complete_event(KIND_NOTE, song_held, b, COUNT_TWO, fin);
                    end
                    else
                    begin
                        complete_event(KIND_CTRL, song_held, b, COUNT_TWO, fin);
                    end
                end
                PH_PROGRAM:
                    complete_event(KIND_PROGRAM, b, 8'd0, COUNT_ONE, fin);
                PH_DELTA:
                begin
                    song_delta = (song_delta << 7) + {25'd0, b[6:0]};
                    if (!b[7])
                    begin
                        song_clock = song_clock + song_delta;
                        song_phase = PH_HEADER;
                    end
                    if (fin)
                    begin
                        close_track(KIND_EOT);
                    end
                end
                default:
                begin
                    if (b == END_MARK)
                    begin
                        close_track(KIND_EOT);
                    end
                    else
                    begin
                        song_header = b;
                        if (b[6:4] >= GRP_LIMIT || fin)
                        begin
                            close_track(KIND_ERROR);
                        end
                        else
                        begin
                            song_phase = PH_FIRST;
                        end
                    end
                end
            endcase
        end
        if (midi_event_q.size() > before_count)
        begin
            midi_event_q[midi_event_q.size() - 1].run_last = 1'b1;
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input bit fin);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            score_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        score_if.valid <= 1'b1;
        score_if.data  <= '{score_byte: b, final_byte: fin};
        do
        begin
            @(posedge clk);
        end
        while (!score_if.ready);
        decode_score_byte(b, fin);
        sent_bytes++;
    endtask

    task automatic settle();
        @(negedge clk);
        score_if.valid <= 1'b0;
        while (midi_event_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic build_event(input bit timed, input logic [2:0] grp, input logic [3:0] chan);
        logic [7:0] note;
        int         delta_len;
        score_q.delete();
        score_q.push_back(make_header(timed, grp, chan));
        case (grp)
            GRP_PLAY:
            begin
                note = 8'($urandom_range(0, 255));
                score_q.push_back(note);
                if (note[7])
                begin
                    score_q.push_back(8'($urandom_range(0, 255)));
                end
            end
            GRP_SYSTEM:
                score_q.push_back(8'($urandom_range(SYS_LOW, SYS_HIGH)));
            GRP_CONTROLLER:
            begin
                score_q.push_back(8'($urandom_range(0, CTRL_LIMIT - 1)));
                score_q.push_back(8'($urandom_range(0, 255)));
            end
            default:
                score_q.push_back(8'($urandom_range(0, 255)));
        endcase
        if (timed)
        begin
            delta_len = ($urandom_range(0, 9) == 0) ? 5 : $urandom_range(1, 2);
            for (int i = 0; i < delta_len; i++)
            begin
                score_q.push_back({i != delta_len - 1, 7'($urandom_range(0, 127))});
            end
        end
    endtask

    task automatic play_random_event();
        build_event($urandom_range(0, 1), 3'($urandom_range(0, 4)),
                    4'($urandom_range(0, 15)));
        foreach (score_q[i])
        begin
            send_byte(score_q[i], 1'b0);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && event_if.valid && event_if.ready)
        begin
            events_seen++;
            if (midi_event_q.size() == 0)
            begin
                $error("unexpected event of kind %0d at time %0d",
                       event_if.data.event_kind, event_if.data.event_time);
                mismatches++;
            end
            else
            begin
                oldest_event = midi_event_q.pop_front();
                check_field("event_kind", 32'(oldest_event.event_kind),
                            32'(event_if.data.event_kind));
                check_field("midi_channel", 32'(oldest_event.midi_channel),
                            32'(event_if.data.midi_channel));
                check_field("first_data", 32'(oldest_event.first_data),
                            32'(event_if.data.first_data));
                check_field("second_data", 32'(oldest_event.second_data),
                            32'(event_if.data.second_data));
                check_field("data_count", 32'(oldest_event.data_count),
                            32'(event_if.data.data_count));
                check_field("event_time", oldest_event.event_time, event_if.data.event_time);
                check_field("run_last", 32'(oldest_event.run_last),
                            32'(event_if.data.run_last));
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                event_if.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                event_if.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 8) - 1;
                event_if.ready <= 1'b0;
            end
            else
            begin
                event_if.ready <= 1'b1;
            end
        end
    end

    task automatic test_directed_events();
        send_byte(make_header(1'b0, GRP_RELEASE, 4'd0), 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(make_header(1'b0, GRP_PLAY, 4'd15), 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(make_header(1'b0, GRP_PLAY, 4'd15), 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(make_header(1'b0, GRP_PLAY, 4'd9), 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(make_header(1'b1, GRP_PITCH, 4'd14), 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(make_header(1'b0, GRP_SYSTEM, 4'd8), 1'b0);
        send_byte(SYS_HIGH, 1'b0);
        send_byte(make_header(1'b1, GRP_CONTROLLER, 4'd1), 1'b0);
        send_byte(CTRL_PROGRAM, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(make_header(1'b0, GRP_CONTROLLER, 4'd3), 1'b0);
        send_byte(CTRL_LIMIT - 8'd1, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(make_header(1'b0, GRP_SYSTEM, 4'd10), 1'b0);
        send_byte(SYS_LOW, 1'b0);
        settle();
    endtask

    task automatic test_random_song();
        while (sent_bytes < 540)
        begin
            play_random_event();
        end
    endtask

    task automatic test_backpressure();
        hold_left = 80;
        repeat (15) play_random_event();
        settle();
    endtask

    task automatic test_steady_stream();
        quiet = 1'b1;
        repeat (30) play_random_event();
    endtask

    // The track can end only once per reset, so each run closes it in one way picked at random.
    task automatic test_track_end();
        logic [7:0] header;
        int         cut;
        case ($urandom_range(0, 7))
            0, 1:
            begin
                ending_name = "end mark";
                send_byte(END_MARK, 1'($urandom_range(0, 1)));
            end
            2, 3, 4:
            begin
                ending_name = "truncated stream";
                build_event($urandom_range(0, 1), 3'($urandom_range(0, 4)),
                            4'($urandom_range(0, 15)));
                cut = $urandom_range(1, score_q.size());
                for (int i = 0; i < cut; i++)
                begin
                    send_byte(score_q[i], i == cut - 1);
                end
            end
            5:
            begin
                ending_name = "bad group";
                header = make_header(1'($urandom_range(0, 1)),
                                     3'($urandom_range(GRP_LIMIT, 7)),
                                     4'($urandom_range(0, 15)));
                if (header == END_MARK)
                begin
                    header[7] = 1'b1;
                end
                send_byte(header, 1'b0);
            end
            6:
            begin
                ending_name = "bad system event";
                send_byte(make_header(1'b0, GRP_SYSTEM, 4'($urandom_range(0, 15))), 1'b0);
                cut = $urandom_range(0, 250);
                send_byte((cut < SYS_LOW) ? 8'(cut) : 8'(cut + 5), 1'b0);
            end
            default:
            begin
                ending_name = "bad controller";
                send_byte(make_header(1'b1, GRP_CONTROLLER, 4'($urandom_range(0, 15))),
                          1'b0);
                send_byte(8'($urandom_range(CTRL_LIMIT, 255)), 1'b0);
            end
        endcase
        settle();
    endtask

    task automatic test_after_end();
        repeat (12) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        settle();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        score_if.valid = 1'b0;
        score_if.data  = '0;
        event_if.ready = 1'b0;
        quiet          = 1'b0;
        hold_left      = 0;
        stall_left     = 0;
        sent_bytes     = 0;
        events_seen    = 0;
        mismatches     = 0;
        song_phase     = PH_HEADER;
        song_header    = '0;
        song_held      = '0;
        song_clock     = '0;
        song_delta     = '0;
        song_stopped   = 1'b0;
        foreach (song_velocity[i])
        begin
            song_velocity[i] = '0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_events();
        test_random_song();
        test_backpressure();
        test_steady_stream();
        test_track_end();
        test_after_end();

        repeat (8) @(posedge clk);
        if (midi_event_q.size() != 0)
        begin
            $error("%0d expected events never arrived", midi_event_q.size());
            mismatches++;
        end
        $display("Covered %0d score bytes and %0d MIDI events under random stalls,",
                 sent_bytes, events_seen);
        $display("a long output hold-off, and a track closed by a %s.", ending_name);
        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
